// ----- design/cbpd_pkg.sv -----
// ----------------------------------------------------------------------------
// cbpd_pkg: shared constants for the Bezier point distance block
// Widths and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package cbpd_pkg;
   localparam int COORD_BITS_DEF  = 24;
   localparam int T_FRAC_BITS_DEF = 16;
   localparam int NUM_REGS        = 8;
   localparam int ADDR_BITS       = 5;

   localparam logic [2:0] REG_C0X = 3'd0;
   localparam logic [2:0] REG_C0Y = 3'd1;
   localparam logic [2:0] REG_C1X = 3'd2;
   localparam logic [2:0] REG_C1Y = 3'd3;
   localparam logic [2:0] REG_C2X = 3'd4;
   localparam logic [2:0] REG_C2Y = 3'd5;
   localparam logic [2:0] REG_C3X = 3'd6;
   localparam logic [2:0] REG_C3Y = 3'd7;
endpackage
`default_nettype wire

// ----- design/cubic_bezier_point_distance.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_point_distance: cubic Bezier evaluation plus point distance
// Bernstein weights from t, weighted sum of four control points, then the
// floor square root of the squared distance to the query point.
// ----------------------------------------------------------------------------
// channel  dir  beats
// req      in   tdata = {t, qy, qx}
// rsp      out  tdata = {dist, cy, cx}
// csr      in   APB register access, 8 control point coordinates
//
// One beat per cycle sustained while rsp accepts. Stages: capture and clamp of t,
// squares of t and 1-t, weights, split control point products, sums,
// differences, difference squares, the radicand register, then one stage
// per root bit in the square root unit.
// Synchronous reset clears the control point registers and all valid bits.
// A stalled rsp freezes the whole pipeline; req_tready = !rsp_tvalid || rsp_tready.
`default_nettype none
module cubic_bezier_point_distance #(
   parameter int COORD_BITS  = cbpd_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cbpd_pkg::T_FRAC_BITS_DEF,
   localparam int IN_RAW  = 2 * COORD_BITS + T_FRAC_BITS + 1,
   localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
   localparam int OUT_RAW = 3 * COORD_BITS + 1,
   localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [IN_W-1:0]      req_tdata,   // query_x, query_y, param_t
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [OUT_W-1:0]     rsp_tdata,   // curve_x, curve_y, distance
   input  wire                  csr_psel,
   input  wire                  csr_penable,
   input  wire                  csr_pwrite,
   input  wire  [cbpd_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire  [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   localparam int CW  = COORD_BITS;
   localparam int TB  = T_FRAC_BITS;
   localparam int TW  = TB + 1;
   localparam int WW  = 3 * TB + 3;         // weight width (3*s^2*t fits)
   localparam int PW  = WW + CW + 1;        // signed product
   localparam int SW  = PW + 2;             // sum of four
   localparam int DW  = CW + 1;             // difference / root
   localparam int RADW = 2 * DW;
   localparam int NS  = 7;
   localparam int LB  = (WW + 1) / 2;       // low weight slice
   localparam int HB  = WW - LB;            // high weight slice
   localparam int LPW = LB + 1 + CW;
   localparam int HPW = HB + 1 + CW;

   // ---------------- configuration registers ----------------
   logic signed [CW-1:0] ctrl_ff [8];
   logic [2:0] reg_idx;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) ctrl_ff[i] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         ctrl_ff[reg_idx] <= csr_pwdata[CW-1:0];
      end
   end
   always_comb begin
      csr_prdata = 32'(ctrl_ff[reg_idx]);
   end

   // ---------------- flow control ----------------
   logic advance;
   logic out_valid;
   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = out_valid;

   logic [NS-1:0] v_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= {v_ff[NS-2:0], req_tvalid};
   end

   // stage 0: capture and clamp t
   logic signed [CW-1:0] qx0_ff, qy0_ff;
   logic [TW-1:0] t0_ff, s0_ff;
   logic [TW-1:0] t_in;
   always_comb begin
      t_in = req_tdata[2*CW +: TW];
      if (t_in > TW'(1) << TB) t_in = TW'(1) << TB;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         qx0_ff <= req_tdata[0 +: CW];
         qy0_ff <= req_tdata[CW +: CW];
         t0_ff  <= t_in;
         s0_ff  <= (TW'(1) << TB) - t_in;
      end
   end

   // stage 1: squares
   logic signed [CW-1:0] qx1_ff, qy1_ff;
   logic [TW-1:0] t1_ff, s1_ff;
   logic [2*TW-1:0] t2_ff, s2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         qx1_ff <= qx0_ff; qy1_ff <= qy0_ff;
         t1_ff <= t0_ff; s1_ff <= s0_ff;
         t2_ff <= t0_ff * t0_ff;
         s2_ff <= s0_ff * s0_ff;
      end
   end

   // stage 2: weights
   logic signed [CW-1:0] qx2_ff, qy2_ff;
   logic [WW-1:0] w_ff [4];
   always_ff @(posedge clock) begin
      if (advance) begin
         qx2_ff <= qx1_ff; qy2_ff <= qy1_ff;
         w_ff[0] <= WW'(s2_ff) * WW'(s1_ff);
         w_ff[1] <= WW'(s2_ff) * WW'(t1_ff) * WW'(3);
         w_ff[2] <= WW'(t2_ff) * WW'(s1_ff) * WW'(3);
         w_ff[3] <= WW'(t2_ff) * WW'(t1_ff);
      end
   end

   // stage 3: weighted control points, weight split in two slices
   logic signed [CW-1:0] qx3_ff, qy3_ff;
   logic signed [LPW-1:0] pxl_ff [4];
   logic signed [LPW-1:0] pyl_ff [4];
   logic signed [HPW-1:0] pxh_ff [4];
   logic signed [HPW-1:0] pyh_ff [4];
   always_ff @(posedge clock) begin
      if (advance) begin
         qx3_ff <= qx2_ff; qy3_ff <= qy2_ff;
         for (int i = 0; i < 4; i++) begin
            pxl_ff[i] <= $signed({1'b0, w_ff[i][LB-1:0]}) * LPW'(ctrl_ff[2*i]);
            pyl_ff[i] <= $signed({1'b0, w_ff[i][LB-1:0]}) * LPW'(ctrl_ff[2*i+1]);
            pxh_ff[i] <= $signed({1'b0, w_ff[i][WW-1:LB]}) * HPW'(ctrl_ff[2*i]);
            pyh_ff[i] <= $signed({1'b0, w_ff[i][WW-1:LB]}) * HPW'(ctrl_ff[2*i+1]);
         end
      end
   end

   // stage 4: sums, truncate toward zero
   logic signed [SW-1:0] sxh_in, syh_in, sxl_in, syl_in, sx_in, sy_in;
   logic rx_in, ry_in;
   logic signed [CW-1:0] qx4_ff, qy4_ff, cx_ff, cy_ff;
   localparam int SH = 3 * TB;
   always_comb begin
      sxh_in = (SW'(pxh_ff[0]) + SW'(pxh_ff[1])) + (SW'(pxh_ff[2]) + SW'(pxh_ff[3]));
      syh_in = (SW'(pyh_ff[0]) + SW'(pyh_ff[1])) + (SW'(pyh_ff[2]) + SW'(pyh_ff[3]));
      sxl_in = (SW'(pxl_ff[0]) + SW'(pxl_ff[1])) + (SW'(pxl_ff[2]) + SW'(pxl_ff[3]));
      syl_in = (SW'(pyl_ff[0]) + SW'(pyl_ff[1])) + (SW'(pyl_ff[2]) + SW'(pyl_ff[3]));
      sx_in  = (sxh_in <<< LB) + sxl_in;
      sy_in  = (syh_in <<< LB) + syl_in;
      // negative sum with dropped fraction: floor is one below truncation
      rx_in  = sx_in[SW-1] && (sx_in[SH-1:0] != '0);
      ry_in  = sy_in[SW-1] && (sy_in[SH-1:0] != '0);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         qx4_ff <= qx3_ff; qy4_ff <= qy3_ff;
         cx_ff <= CW'(sx_in >>> SH) + CW'(rx_in);
         cy_ff <= CW'(sy_in >>> SH) + CW'(ry_in);
      end
   end

   // stage 5: abs differences
   logic signed [CW-1:0] cx5_ff, cy5_ff;
   logic [DW-1:0] dx_ff, dy_ff;
   logic signed [DW-1:0] ddx_in, ddy_in;
   always_comb begin
      ddx_in = DW'(cx_ff) - DW'(qx4_ff);
      ddy_in = DW'(cy_ff) - DW'(qy4_ff);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         cx5_ff <= cx_ff; cy5_ff <= cy_ff;
         dx_ff <= ddx_in[DW-1] ? DW'(-ddx_in) : DW'(ddx_in);
         dy_ff <= ddy_in[DW-1] ? DW'(-ddy_in) : DW'(ddy_in);
      end
   end

   // stage 6: squares
   logic signed [CW-1:0] cx6_ff, cy6_ff;
   logic [RADW-1:0] dx2_ff, dy2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cx6_ff <= cx5_ff; cy6_ff <= cy5_ff;
         dx2_ff <= RADW'(dx_ff) * RADW'(dx_ff);
         dy2_ff <= RADW'(dy_ff) * RADW'(dy_ff);
      end
   end

   // square root unit, stage 7 onward
   logic [DW-1:0] root;
   logic [2*CW-1:0] pay;
   cbpd_sqrt #(.RAD_BITS(RADW), .ROOT_BITS(DW), .PAY_BITS(2*CW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (v_ff[NS-1]),
      .in_rad   (dx2_ff + dy2_ff),
      .in_pay   ({cy6_ff, cx6_ff}),
      .out_valid(out_valid),
      .out_root (root),
      .out_pay  (pay)
   );

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[2*CW-1:0]    = pay;
      rsp_tdata[2*CW +: DW]  = root;
   end
endmodule
`default_nettype wire

// ----- design/cbpd_sqrt.sv -----
// ----------------------------------------------------------------------------
// cbpd_sqrt: pipelined integer square root
// One trial-square step per root bit, floor(sqrt(radicand)), payload carried along.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpd_sqrt #(
   parameter int RAD_BITS  = 50,
   parameter int ROOT_BITS = 25,
   parameter int PAY_BITS  = 48
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  wire                   in_valid,
   input  wire  [RAD_BITS-1:0]   in_rad,
   input  wire  [PAY_BITS-1:0]   in_pay,
   output logic                  out_valid,
   output logic [ROOT_BITS-1:0]  out_root,
   output logic [PAY_BITS-1:0]   out_pay
);
   localparam int RW = 2 * ROOT_BITS;
   logic [ROOT_BITS:0]     valid_ff;
   logic [RW-1:0]          rem_ff  [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]   root_ff [ROOT_BITS+1];
   logic [PAY_BITS-1:0]    pay_ff  [ROOT_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[ROOT_BITS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= RW'(in_rad);
         root_ff[0] <= '0;
         pay_ff[0]  <= in_pay;
      end
   end

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
      localparam int B = ROOT_BITS - 1 - k;
      logic [RW+1:0] trial_in;
      logic [ROOT_BITS-1:0] cand_in;
      always_comb begin
         cand_in  = root_ff[k] | (ROOT_BITS'(1) << B);
         trial_in = (RW+2)'(cand_in) * (RW+2)'(cand_in);
      end
      // square of the candidate, compared in this stage; only the chosen root is registered
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= rem_ff[k];
            root_ff[k+1] <= (trial_in <= (RW+2)'(rem_ff[k])) ? cand_in : root_ff[k];
            pay_ff[k+1]  <= pay_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS];
   assign out_root  = root_ff[ROOT_BITS];
   assign out_pay   = pay_ff[ROOT_BITS];
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for cubic_bezier_point_distance
// Streams query points and curve parameters through the block under random
// valid/ready gaps and checks the curve point and the distance of each beat.
// The expected values are computed here, exactly, from the control points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds predicted curve points and distances in beat order.
class curve_scoreboard;
   logic [23:0] ctrl_x [4];
   logic [23:0] ctrl_y [4];
   logic [72:0] pending_q [$];
   int          mismatches;
   int          checked;

   function new();
      for (int i = 0; i < 4; i++) begin
         ctrl_x[i] = '0;
         ctrl_y[i] = '0;
      end
      mismatches = 0;
      checked    = 0;
   endfunction

   function void set_reg(int idx, logic [23:0] value);
      if (idx % 2 == 0) ctrl_x[idx / 2] = value;
      else ctrl_y[idx / 2] = value;
   endfunction

   // Weighted sum of four coordinates, truncated toward zero.
   function logic signed [23:0] blend(logic [16:0] t, logic [23:0] c [4]);
      logic signed [127:0] acc;
      logic signed [127:0] w [4];
      logic signed [127:0] s;
      logic signed [127:0] tt;
      logic signed [127:0] q;
      s   = 65536 - t;
      tt  = t;
      w[0] = s * s * s;
      w[1] = 3 * s * s * tt;
      w[2] = 3 * s * tt * tt;
      w[3] = tt * tt * tt;
      acc = 0;
      for (int i = 0; i < 4; i++)
         acc += w[i] * 128'(signed'(c[i]));
      if (acc < 0) q = -((-acc) >>> 48);
      else q = acc >>> 48;
      return q[23:0];
   endfunction

   function void note_request(logic [23:0] qx, logic [23:0] qy, logic [16:0] t_in);
      logic [16:0] t;
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [63:0] sq;
      logic [63:0] root;
      logic [63:0] cand;
      t  = (t_in > 17'd65536) ? 17'd65536 : t_in;
      cx = blend(t, ctrl_x);
      cy = blend(t, ctrl_y);
      dx = 64'(cx) - 64'(signed'(qx));
      dy = 64'(cy) - 64'(signed'(qy));
      sq = dx * dx + dy * dy;
      root = 0;
      for (int b = 24; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= sq) root = cand;
      end
      pending_q.push_back({root[24:0], cy, cx});
   endfunction

   function void check_response(logic [79:0] data);
      logic [72:0] want;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected beat %h", data);
         return;
      end
      want = pending_q.pop_front();
      checked++;
      if (data[23:0] !== want[23:0] || data[47:24] !== want[47:24] ||
          data[72:48] !== want[72:48] || data[79:73] !== 7'd0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: cx %h/%h cy %h/%h dist %h/%h (exp/act)",
                     want[23:0], data[23:0], want[47:24], data[47:24],
                     want[72:48], data[72:48]);
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // query_x, query_y, param_t, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;        // curve_x, curve_y, distance, zero pad
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [cbpd_pkg::ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   curve_scoreboard board = new();
   int  hold_cycles = 0;   // long receiver hold-off, counted in its own process
   int  sent = 0;

   // 8 front stages incl. radicand register, plus one per root bit
   localparam int LATENCY = 8 + 25;

   cubic_bezier_point_distance dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls, plus the hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 0;
      end else rsp_tready <= ($urandom_range(0, 99) < 75);
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);

   task automatic csr_write(int idx, logic [23:0] value);
      @(posedge clock);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= cbpd_pkg::ADDR_BITS'(4 * idx);
      csr_pwdata  <= {{8{value[23]}}, value};
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      board.set_reg(idx, value);
   endtask

   // one beat; valid stays up into the next beat unless a gap follows
   task automatic send_beat(logic [23:0] qx, logic [23:0] qy, logic [16:0] t,
                            bit no_gap);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {7'd0, t, qy, qx};
      do @(posedge clock); while (!req_tready);
      board.note_request(qx, qy, t);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function logic [23:0] rand_coord(int mode);
      case (mode)
         0: return 24'h800000;
         1: return 24'h7fffff;
         2: return 24'(signed'($urandom_range(0, 4000)) - 2000);
         default: return 24'($urandom);
      endcase
   endfunction

   function logic [16:0] rand_t();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 17'd0;
      if (r < 10) return 17'd65536;
      if (r < 18) return 17'($urandom_range(65537, 131071));
      return 17'($urandom_range(0, 65536));
   endfunction

   initial begin
      int mode;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: reset curve, extremes of query and t, t above one
      send_beat(24'h000000, 24'h000000, 17'd0, 0);
      send_beat(24'h800000, 24'h800000, 17'd65536, 0);
      send_beat(24'h7fffff, 24'h800000, 17'h1ffff, 0);
      drain();
      // extreme control points: opposite corners for max distance
      for (int i = 0; i < 8; i++) csr_write(i, (i < 4) ? 24'h800000 : 24'h7fffff);
      send_beat(24'h7fffff, 24'h7fffff, 17'd0, 0);
      send_beat(24'h800000, 24'h800000, 17'd65536, 0);
      send_beat(24'h800000, 24'h7fffff, 17'd32768, 0);
      send_beat(24'h000000, 24'h000000, 17'd1, 0);
      send_beat(24'h123456, 24'hedcba9, 17'd65535, 0);
      send_beat(24'h7fffff, 24'h800000, 17'd65537, 0);
      send_beat(24'h000001, 24'hffffff, 17'h10000, 0);
      drain();

      // random phases, each with new control points
      for (int ph = 0; ph < 10; ph++) begin
         mode = ph % 4;
         for (int i = 0; i < 8; i++) csr_write(i, rand_coord((mode + i) % 4));
         if (ph == 3) hold_cycles = 300;  // back up the pipeline
         for (int n = 0; n < 125; n++)
            send_beat(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                      rand_t(), (ph == 3) || ($urandom_range(0, 3) == 0));
         drain();
      end

      $display("sent %0d beats over 12 control point settings, %0d results checked",
               sent, board.checked);
      if (board.mismatches == 0 && board.pending_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
